// File: rtl/nidt_pkg.sv
package nidt_pkg;

  localparam int ID_W        = 8;
  localparam int UUID_HALF_W = 64;
  localparam int TABLE_DEPTH = 256;
  localparam int SCAN_W      = ID_W + 1;

  typedef logic [ID_W-1:0]          node_id_t;
  typedef logic [UUID_HALF_W-1:0]   uuid_half_t;

  typedef struct packed {
    uuid_half_t upper;
    uuid_half_t lower;
  } uuid_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DEL    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DUP,
    S_INSERT,
    S_RSCAN,
    S_LOOK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic     rd_en;
    node_id_t rd_addr;
    logic     wr_en;
    node_id_t wr_addr;
    uuid_t    wr_data;
  } mem_req_t;

endpackage

// File: rtl/nidt_uuid_mem.sv
module nidt_uuid_mem (
  input  logic              clk,
  input  nidt_pkg::mem_req_t req,
  output nidt_pkg::uuid_t    rd_data
);

  nidt_pkg::uuid_t mem [nidt_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// File: rtl/nidt_ctrl.sv
module nidt_ctrl #(
  parameter int NODE_IDS = 255
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            opcode,
  input  logic [7:0]            node_id,
  input  logic [63:0]           uuid_upper_in,
  input  logic [63:0]           uuid_lower_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  success,
  output logic [63:0]           uuid_upper_out,
  output logic [63:0]           uuid_lower_out,
  output logic [7:0]            next_free_id,
  output logic [7:0]            node_count,
  output nidt_pkg::mem_req_t    mem_req,
  input  nidt_pkg::uuid_t       mem_rd_data
);

  localparam logic [nidt_pkg::SCAN_W-1:0] LAST_ID   = nidt_pkg::SCAN_W'(NODE_IDS);
  localparam logic [nidt_pkg::ID_W-1:0]   LAST_ID8  = nidt_pkg::ID_W'(NODE_IDS);
  localparam logic [nidt_pkg::ID_W-1:0]   LAST_ITER = nidt_pkg::ID_W'(NODE_IDS - 1);

  nidt_pkg::state_t   state, state_next;
  nidt_pkg::op_t      item_op, item_op_next;
  nidt_pkg::node_id_t item_id, item_id_next;
  nidt_pkg::uuid_t    item_uuid, item_uuid_next;

  logic [nidt_pkg::TABLE_DEPTH-1:0] occ, occ_next;
  nidt_pkg::node_id_t next_id, next_id_next;
  nidt_pkg::node_id_t count, count_next;

  logic [nidt_pkg::SCAN_W-1:0] scan_k, scan_k_next;
  logic                        rd_pend, rd_pend_next;
  nidt_pkg::node_id_t          rd_id, rd_id_next;
  nidt_pkg::node_id_t          ptr, ptr_next;
  nidt_pkg::node_id_t          iter, iter_next;

  logic            res_ok, res_ok_next;
  nidt_pkg::uuid_t res_uuid, res_uuid_next;

  logic            out_valid_next;
  logic            out_load;
  logic            id_ok;

  assign id_ok = (item_id != '0) && ({1'b0, item_id} <= LAST_ID);

  always_comb begin
    state_next     = state;
    item_op_next   = item_op;
    item_id_next   = item_id;
    item_uuid_next = item_uuid;
    occ_next       = occ;
    next_id_next   = next_id;
    count_next     = count;
    scan_k_next    = scan_k;
    rd_pend_next   = 1'b0;
    rd_id_next     = rd_id;
    ptr_next       = ptr;
    iter_next      = iter;
    res_ok_next    = res_ok;
    res_uuid_next  = res_uuid;
    out_load       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    mem_req        = '0;
    in_ready       = (state == nidt_pkg::S_IDLE);

    unique case (state)
      nidt_pkg::S_IDLE: begin
        if (in_valid) begin
          item_op_next         = nidt_pkg::op_t'(opcode);
          item_id_next         = node_id;
          item_uuid_next.upper = uuid_upper_in;
          item_uuid_next.lower = uuid_lower_in;
          res_ok_next          = 1'b0;
          res_uuid_next        = '0;
          state_next           = nidt_pkg::S_EXEC;
        end
      end

      nidt_pkg::S_EXEC: begin
        state_next = nidt_pkg::S_OUT;
        if (id_ok) begin
          unique case (item_op)
            nidt_pkg::OP_ADD: begin
              scan_k_next = nidt_pkg::SCAN_W'(1);
              state_next  = nidt_pkg::S_DUP;
            end
            nidt_pkg::OP_DEL: begin
              if (occ[item_id]) begin
                occ_next[item_id] = 1'b0;
                count_next        = count - 8'd1;
                res_ok_next       = 1'b1;
                if (next_id == '0 || item_id < next_id) begin
                  next_id_next = item_id;
                end
              end
            end
            nidt_pkg::OP_LOOKUP: begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = item_id;
              state_next      = nidt_pkg::S_LOOK;
            end
            default: begin
              state_next = nidt_pkg::S_OUT;
            end
          endcase
        end
      end

      // read of entry k issued here, compared in the following cycle
      nidt_pkg::S_DUP: begin
        if (scan_k <= LAST_ID) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = scan_k[nidt_pkg::ID_W-1:0];
          rd_pend_next    = 1'b1;
          rd_id_next      = scan_k[nidt_pkg::ID_W-1:0];
          scan_k_next     = scan_k + 1'b1;
        end
        if (rd_pend) begin
          if (occ[rd_id] && mem_rd_data == item_uuid) begin
            occ_next[rd_id] = 1'b0;
            count_next      = count - 8'd1;
            rd_pend_next    = 1'b0;
            state_next      = nidt_pkg::S_INSERT;
          end else if (rd_id == LAST_ID8) begin
            rd_pend_next = 1'b0;
            state_next   = nidt_pkg::S_INSERT;
          end
        end
      end

      nidt_pkg::S_INSERT: begin
        if (!occ[item_id]) begin
          occ_next[item_id] = 1'b1;
          count_next        = count + 8'd1;
          res_ok_next       = 1'b1;
          mem_req.wr_en     = 1'b1;
          mem_req.wr_addr   = item_id;
          mem_req.wr_data   = item_uuid;
        end
        ptr_next   = (next_id == '0) ? 8'd1 : next_id;
        iter_next  = '0;
        state_next = nidt_pkg::S_RSCAN;
      end

      nidt_pkg::S_RSCAN: begin
        if (!occ[ptr]) begin
          next_id_next = ptr;
          state_next   = nidt_pkg::S_OUT;
        end else if (iter == LAST_ITER) begin
          next_id_next = '0;
          state_next   = nidt_pkg::S_OUT;
        end else begin
          ptr_next  = (ptr == LAST_ID8) ? 8'd1 : ptr + 8'd1;
          iter_next = iter + 8'd1;
        end
      end

      nidt_pkg::S_LOOK: begin
        if (occ[item_id]) begin
          res_ok_next   = 1'b1;
          res_uuid_next = mem_rd_data;
        end
        state_next = nidt_pkg::S_OUT;
      end

      nidt_pkg::S_OUT: begin
        if (!out_valid || out_ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = nidt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = nidt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nidt_pkg::S_IDLE;
      occ       <= '0;
      next_id   <= 8'd1;
      count     <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      next_id   <= next_id_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      rd_pend   <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    item_op   <= item_op_next;
    item_id   <= item_id_next;
    item_uuid <= item_uuid_next;
    scan_k    <= scan_k_next;
    rd_id     <= rd_id_next;
    ptr       <= ptr_next;
    iter      <= iter_next;
    res_ok    <= res_ok_next;
    res_uuid  <= res_uuid_next;
    if (out_load) begin
      success        <= res_ok;
      uuid_upper_out <= res_uuid.upper;
      uuid_lower_out <= res_uuid.lower;
      next_free_id   <= next_id;
      node_count     <= count;
    end
  end

endmodule

// File: rtl/node_id_allocation_table_unit.sv
// Node ID table: binds IDs 1..NODE_IDS to 128-bit UUIDs, with occupancy flags,
// a next-free pointer and a node count. Every input word gives one output word
// (status, UUID on a lookup hit, pointer, count). One word is handled at a time;
// a new word is taken while the previous result still waits at the output.
// Delete, invalid ID and unused opcode go straight to the result register; a
// lookup first reads the UUID RAM. An add runs two walks first: the duplicate-UUID
// search reads the UUID RAM one entry a cycle, then the pointer refresh walks
// the occupancy flags one ID a cycle. The UUID RAM needs no clearing after
// reset.
module node_id_allocation_table_unit #(
  parameter int NODE_IDS = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  node_id,
  input  logic [63:0] uuid_upper_in,
  input  logic [63:0] uuid_lower_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        success,
  output logic [63:0] uuid_upper_out,
  output logic [63:0] uuid_lower_out,
  output logic [7:0]  next_free_id,
  output logic [7:0]  node_count
);

  nidt_pkg::mem_req_t mem_req;
  nidt_pkg::uuid_t    mem_rd_data;

  nidt_ctrl #(
    .NODE_IDS(NODE_IDS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .node_id        (node_id),
    .uuid_upper_in  (uuid_upper_in),
    .uuid_lower_in  (uuid_lower_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .success        (success),
    .uuid_upper_out (uuid_upper_out),
    .uuid_lower_out (uuid_lower_out),
    .next_free_id   (next_free_id),
    .node_count     (node_count),
    .mem_req        (mem_req),
    .mem_rd_data    (mem_rd_data)
  );

  nidt_uuid_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

endmodule
